/* design/tbh_pkg.sv */
// Shared types, constants and helper functions for the toy block hash unit.
// No dependencies; every other design file imports this package.
package tbh_pkg;

    localparam int BLOCK_BYTES     = 64;
    localparam int BlockWords      = BLOCK_BYTES / 4;
    localparam int CountW          = $clog2(BLOCK_BYTES) + 1;
    localparam int WordSelW        = $clog2(BlockWords);
    localparam int HashWords       = 8;
    localparam int HashIdxW        = $clog2(HashWords);
    localparam int KeyIdxW         = 4;
    localparam int MaxRounds       = 16;
    localparam int ROUND_COUNT_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] PadByte = 8'h80;

    // Block as sixteen big-endian words, word 0 holds bytes 0..3
    typedef logic [BlockWords-1:0][31:0] t_block;

    function automatic logic [31:0] init_word(input logic [HashIdxW-1:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_key(input logic [KeyIdxW-1:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'h428a2f98;
            4'd1:    v = 32'h71374491;
            4'd2:    v = 32'hb5c0fbcf;
            4'd3:    v = 32'he9b5dba5;
            4'd4:    v = 32'h3956c25b;
            4'd5:    v = 32'h59f111f1;
            4'd6:    v = 32'h923f82a4;
            4'd7:    v = 32'hab1c5ed5;
            4'd8:    v = 32'hd807aa98;
            4'd9:    v = 32'h12835b01;
            4'd10:   v = 32'h243185be;
            4'd11:   v = 32'h550c7dc3;
            4'd12:   v = 32'h72be5d74;
            4'd13:   v = 32'h80deb1fe;
            4'd14:   v = 32'h9bdc06a7;
            4'd15:   v = 32'hc19bf174;
            default: v = 32'h428a2f98;
        endcase
        return v;
    endfunction

    // Rotate right by a constant amount
    function automatic logic [31:0] ror32(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

endpackage

/* design/tbh_front.sv */
// Front end of the toy block hash: packs message bytes into a block and pads it.
// Depends on tbh_pkg; pushes finished blocks into tbh_queue.
module tbh_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_msg_byte,
    input  logic           i_has_byte,
    input  logic           i_last_byte,
    output logic           o_push,
    input  logic           i_push_ready,
    output tbh_pkg::t_block o_block
);
    import tbh_pkg::*;

    t_block              r_blk;
    t_block              n_blk;
    t_block              pad_blk;
    logic [CountW-1:0]   r_cnt;
    logic [CountW-1:0]   n_cnt;
    logic                accept;

    // Plain bytes never need queue space; a closing item does
    assign o_ready = i_push_ready || !i_last_byte;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_blk = r_blk;
        n_cnt = r_cnt;
        if (i_has_byte && (r_cnt < CountW'(BLOCK_BYTES))) begin
            n_blk[r_cnt[CountW-2:2]][{~r_cnt[1:0], 3'b000} +: 8] = i_msg_byte;
            n_cnt = r_cnt + 1'b1;
        end
        pad_blk = n_blk;
        if (n_cnt < CountW'(BLOCK_BYTES)) begin
            pad_blk[n_cnt[CountW-2:2]][{~n_cnt[1:0], 3'b000} +: 8] = PadByte;
        end
    end

    assign o_push  = accept && i_last_byte;
    assign o_block = pad_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_blk <= '0;
                r_cnt <= '0;
            end else begin
                r_blk <= n_blk;
                r_cnt <= n_cnt;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CountW'(BLOCK_BYTES))
        else $error("byte count ran past the block size");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_cnt == '0 && r_blk == '0))
        else $error("block buffer not cleared after a closing item");

endmodule

/* design/tbh_queue.sv */
// Short block queue between the packing front end and the round engine.
// Depends on tbh_pkg for the block type.
module tbh_queue #(
    parameter int QUEUE_DEPTH = tbh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  tbh_pkg::t_block i_block,
    output logic            o_valid,
    input  logic            i_pop,
    output tbh_pkg::t_block o_block
);
    import tbh_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_block            r_slot [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic              do_pop;

    assign o_push_ready = (r_count != CntW'(QUEUE_DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_block      = r_slot[r_rd_ptr];
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CntW'(QUEUE_DEPTH)))
        else $error("block pushed into a full queue");

endmodule

/* design/tbh_back.sv */
// Round engine of the toy block hash: runs the rounds one sub-step per cycle,
// adds the initial value back and streams eight words out. Depends on tbh_pkg.
module tbh_back #(
    parameter int ROUND_COUNT = tbh_pkg::ROUND_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_blk_valid,
    output logic                          o_blk_ready,
    input  tbh_pkg::t_block               i_block,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [31:0]                   o_hash_word,
    output logic [tbh_pkg::HashIdxW-1:0]  o_word_index,
    output logic                          o_word_last
);
    import tbh_pkg::*;

    localparam int RoundW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    t_state                r_state;
    t_block                r_blk;
    logic [31:0]           r_work [HashWords];
    logic [31:0]           r_t1;
    logic [31:0]           r_t;
    logic [1:0]            r_sub;
    logic [RoundW-1:0]     r_round;
    logic [HashIdxW-1:0]   r_idx;
    logic                  r_out_valid;
    logic [31:0]           r_out_word;
    logic [HashIdxW-1:0]   r_out_idx;
    logic                  r_out_last;
    logic                  out_load;

    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] sum;
    logic [31:0] t_new;

    assign a = r_work[0];
    assign b = r_work[1];
    assign c = r_work[2];
    assign d = r_work[3];
    assign e = r_work[4];
    assign f = r_work[5];
    assign g = r_work[6];
    assign h = r_work[7];

    // One quarter of a round; the block words sit at taps 0..3
    always_comb begin
        case (r_sub)
            2'd0: begin
                sum   = a + (e ^ (b & (c ^ e))) + r_blk[0] + round_key(KeyIdxW'(r_round));
                t_new = h + ror32(sum, 7);
            end
            2'd1: begin
                sum   = r_t + (f ^ (a & (b ^ f))) + r_blk[1];
                t_new = d + ror32(sum, 11);
            end
            2'd2: begin
                sum   = r_t + (g ^ (d & (a ^ g))) + r_blk[2];
                t_new = c + ror32(sum, 19);
            end
            2'd3: begin
                sum   = r_t + (h ^ (c & (d ^ h))) + r_blk[3];
                t_new = b + ror32(sum, 3);
            end
            default: begin
                sum   = '0;
                t_new = '0;
            end
        endcase
    end

    // Load the next word when the output register is empty or being taken
    assign out_load     = (r_state == ST_OUT) && (!r_out_valid || i_ready);

    assign o_blk_ready  = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_hash_word  = r_out_word;
    assign o_word_index = r_out_idx;
    assign o_word_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sub       <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_blk_valid) begin
                        r_blk   <= i_block;
                        for (int i = 0; i < HashWords; i++) begin
                            r_work[i] <= init_word(HashIdxW'(i));
                        end
                        r_sub   <= '0;
                        r_round <= '0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_t   <= t_new;
                    r_sub <= r_sub + 1'b1;
                    if (r_sub == 2'd0) begin
                        r_t1 <= t_new;
                    end
                    if (r_sub == 2'd3) begin
                        r_work[0] <= t_new;
                        r_work[1] <= c;
                        r_work[2] <= d;
                        r_work[3] <= e;
                        r_work[4] <= f;
                        r_work[5] <= g;
                        r_work[6] <= h;
                        r_work[7] <= r_t1;
                        // Advance the block by four words for the next round
                        for (int j = 0; j < BlockWords; j++) begin
                            r_blk[j] <= r_blk[(j + 4) % BlockWords];
                        end
                        r_round <= r_round + 1'b1;
                        if (r_round == RoundW'(ROUND_COUNT - 1)) begin
                            r_state <= ST_FINAL;
                        end
                    end
                end
                ST_FINAL: begin
                    for (int i = 0; i < HashWords; i++) begin
                        r_work[i] <= r_work[i] + init_word(HashIdxW'(i));
                    end
                    r_idx   <= '0;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_out_word  <= r_work[r_idx];
                        r_out_idx   <= r_idx;
                        r_out_last  <= (r_idx == HashIdxW'(HashWords - 1));
                        r_idx       <= r_idx + 1'b1;
                        if (r_idx == HashIdxW'(HashWords - 1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round <= RoundW'(ROUND_COUNT - 1)))
        else $error("round counter ran past the round count");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word_last) |-> (o_word_index == HashIdxW'(HashWords - 1)))
        else $error("last flag on a word other than the eighth");

endmodule

/* design/toy_block_hash_256_unit.sv */
// Top level of the toy block hash unit: byte packer, block queue, round engine.
// Depends on tbh_pkg, tbh_front, tbh_queue and tbh_back.
//
// Usage:
//   Input channel (i_valid/o_ready): one item per accepted cycle, carrying
//   i_msg_byte, i_has_byte and i_last_byte. Bytes pack big-endian into a
//   64-byte block; bytes past the 64th are dropped. An item with
//   i_last_byte set closes the message: the block is padded with 0x80
//   (unless full), handed to the block queue, and the byte buffer clears.
//   Output channel (o_valid/i_ready): eight items per message, hash words
//   0 through 7, with o_word_last on the eighth.
//   Throughput: one byte item per cycle while o_ready is high. Per message the
//   round engine runs ROUND_COUNT rounds, one quarter round per cycle, then
//   the final add, then streams one word per cycle out while i_ready is high.
//   The queue holds QUEUE_DEPTH_DEF closed blocks, so new messages keep
//   loading while the engine works; o_ready drops only for a closing item
//   when the queue is full.
//   Reset (synchronous, active low) empties the buffer, queue and engine.
//   A stalled receiver holds the current word in the output register; the
//   engine waits, and once it finishes streaming it takes the next block.
module toy_block_hash_256_unit #(
    parameter int ROUND_COUNT = tbh_pkg::ROUND_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_word,
    output logic [2:0]  o_word_index,
    output logic        o_word_last
);
    import tbh_pkg::*;

    logic   push;
    logic   push_ready;
    t_block push_block;
    logic   q_valid;
    logic   q_pop;
    t_block q_block;

    // Pack and pad bytes; hand closed blocks to the queue
    tbh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_msg_byte   (i_msg_byte),
        .i_has_byte   (i_has_byte),
        .i_last_byte  (i_last_byte),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_block      (push_block)
    );

    // Hold closed blocks until the engine is free
    tbh_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_block      (push_block),
        .o_valid      (q_valid),
        .i_pop        (q_pop),
        .o_block      (q_block)
    );

    // Run the rounds and stream the hash words
    tbh_back #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_blk_valid  (q_valid),
        .o_blk_ready  (q_pop),
        .i_block      (q_block),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_word  (o_hash_word),
        .o_word_index (o_word_index),
        .o_word_last  (o_word_last)
    );

endmodule
